// ----- hdl/swv_pkg.sv -----
// Shared types and codes for the sliding window symbol voter.
// Holds the sequencer states, result event codes and register indexes.
// No dependencies.
`default_nettype none

package swv_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_SIZE  = 2'd0,
		REG_MIN_VOTES    = 2'd1,
		REG_MIN_SHARE_Q8 = 2'd2,
		REG_LOST_LIMIT   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_CHANGED = 2'd1,
		EV_LOST    = 2'd2
	} vote_ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_OUTER,
		ST_CUR,
		ST_INNER,
		ST_EVAL,
		ST_DECIDE,
		ST_EMIT
	} swv_state_t;

endpackage

`default_nettype wire

// ----- hdl/swv_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set the word width and the depth. No dependencies.
`default_nettype none

module swv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/sliding_window_symbol_voter.sv -----
// Sliding window majority voter over per-frame recognition results.
// Clear items and lost symbols skip the vote; a frame's vote is a pairwise count over the
// valid window entries through the single history RAM read port, and output stalls hold the
// result. One item at a time; a result waiting in the output register does not block the
// next item. Reset clears control state and the history valid bits and loads register
// defaults; the history RAM is not cleared.
`default_nettype none

module sliding_window_symbol_voter #(
	parameter int WINDOW_MAX = 16,
	parameter int ID_BITS    = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [swv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swv_pkg::CFG_DATA_W-1:0] cfg_data,

	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           req_type,
	input  wire logic                           frame_valid,
	input  wire logic [15:0]                    symbol_id,

	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [1:0]                     vote_event,
	output logic                                has_stable,
	output logic      [15:0]                    stable_id,
	output logic      [4:0]                     window_fill,
	output logic      [4:0]                     valid_in_window
);

	import swv_pkg::*;

	localparam int IDX_W  = $clog2(WINDOW_MAX);
	localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int PROD_W = CNT_W + 9;
	localparam logic [7:0] WMAX8 = 8'(WINDOW_MAX);

	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] pos);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(pos);
		if (sum >= SUM_W'(WINDOW_MAX)) begin
			sum = sum - SUM_W'(WINDOW_MAX);
		end
		return sum[IDX_W-1:0];
	endfunction

	swv_state_t state_q, state_d;

	logic [4:0]   window_size_q;
	logic [4:0]   min_votes_q;
	logic [8:0]   min_share_q;
	logic [7:0]   lost_limit_q;

	logic [WINDOW_MAX-1:0] hv_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      head_q;
	logic [CNT_W-1:0]      nvalid_q;
	logic [7:0]            run_q;
	logic                  stable_q;
	logic [ID_BITS-1:0]    stable_sym_q;

	logic [CNT_W-1:0]   p_q;
	logic [CNT_W-1:0]   q_q;
	logic [CNT_W-1:0]   c_q;
	logic               seen_q;
	logic [ID_BITS-1:0] cur_q;
	logic               have_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [ID_BITS-1:0] best_sym_q;
	vote_ev_t           ev_q;

	logic               live_s1;
	logic [CNT_W-1:0]   pos_s1;
	logic               hv_s1;

	logic               out_valid_q;
	vote_ev_t           out_ev_q;
	logic               out_has_q;
	logic [ID_BITS-1:0] out_sym_q;
	logic [CNT_W-1:0]   out_fill_q;
	logic [CNT_W-1:0]   out_nvalid_q;

	logic               in_acc;
	logic               cfg_acc;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_raddr;
	logic [ID_BITS-1:0] ram_rdata;

	logic [7:0]         ws8, mv8;
	logic [CNT_W-1:0]   eff_w, eff_mv;
	logic [8:0]         eff_share;
	logic [7:0]         eff_limit;
	logic               full;
	logic [IDX_W-1:0]   new_head;
	logic [CNT_W-1:0]   keep_cnt;
	logic [IDX_W-1:0]   wslot;
	logic [31:0]        sym_ext;
	logic [ID_BITS-1:0] sym_in;
	logic [ID_BITS-1:0] sym_wr;
	logic               drop_valid;
	logic [IDX_W-1:0]   p_slot, q_slot;
	logic               lost;
	logic               inner_live;
	logic               inner_done;
	logic               cand_ok;
	logic               emit_ok;
	logic [PROD_W-1:0]  share_lhs, share_rhs;
	logic [31:0]        stable_ext;

	// effective register values
	always_comb begin
		ws8 = 8'(window_size_q);
		if (ws8 == 8'd0) begin
			eff_w = CNT_W'(1);
		end else if (ws8 > WMAX8) begin
			eff_w = CNT_W'(WMAX8);
		end else begin
			eff_w = CNT_W'(ws8);
		end
		mv8 = 8'(min_votes_q);
		if (mv8 == 8'd0) begin
			eff_mv = CNT_W'(1);
		end else if (mv8 > 8'(eff_w)) begin
			eff_mv = eff_w;
		end else begin
			eff_mv = CNT_W'(mv8);
		end
		if (min_share_q == 9'd0) begin
			eff_share = 9'd1;
		end else if (min_share_q > 9'd256) begin
			eff_share = 9'd256;
		end else begin
			eff_share = min_share_q;
		end
		eff_limit = (lost_limit_q == 8'd0) ? 8'd1 : lost_limit_q;
	end

	assign in_acc  = in_valid && !in_stall;
	assign cfg_acc = cfg_valid && cfg_ready;

	assign full       = count_q >= eff_w;
	assign new_head   = full ? slot_of(head_q, CNT_W'(1)) : head_q;
	assign keep_cnt   = full ? eff_w - CNT_W'(1) : count_q;
	assign wslot      = slot_of(new_head, keep_cnt);
	assign sym_ext    = 32'(symbol_id);
	assign sym_in     = sym_ext[ID_BITS-1:0];
	assign sym_wr     = frame_valid ? sym_in : '0;
	assign drop_valid = full && hv_q[head_q];

	assign p_slot     = slot_of(head_q, p_q);
	assign q_slot     = slot_of(head_q, q_q);
	assign lost       = stable_q && (run_q >= eff_limit);
	assign inner_live = q_q < count_q;
	assign inner_done = !inner_live && !live_s1;

	assign share_lhs = PROD_W'({c_q, 8'd0});
	assign share_rhs = PROD_W'(eff_share) * PROD_W'(nvalid_q);
	assign cand_ok   = !seen_q && (c_q >= eff_mv) && (share_lhs >= share_rhs)
		&& (!have_q || c_q > best_cnt_q);
	assign emit_ok   = !out_valid_q || !out_stall;

	swv_ram #(
		.WIDTH(ID_BITS),
		.DEPTH(WINDOW_MAX)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wslot),
		.wdata(sym_wr),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = req_type ? ST_EMIT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = lost ? ST_EMIT : ST_OUTER;
			end
			ST_OUTER: begin
				if (hv_q[p_slot]) begin
					state_d = ST_CUR;
				end else if (p_q == '0) begin
					state_d = ST_DECIDE;
				end
			end
			ST_CUR: begin
				state_d = ST_INNER;
			end
			ST_INNER: begin
				if (inner_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = (p_q == '0) ? ST_DECIDE : ST_OUTER;
			end
			ST_DECIDE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs; a register write takes the idle cycle ahead of an item
	always_comb begin
		in_stall  = (state_q != ST_IDLE) || cfg_valid;
		cfg_ready = (state_q == ST_IDLE);
		ram_we    = in_acc && !req_type;
		ram_raddr = (state_q == ST_INNER) ? q_slot : p_slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= 5'd16;
			min_votes_q   <= 5'd3;
			min_share_q   <= 9'd128;
			lost_limit_q  <= 8'd5;
			hv_q          <= '0;
			count_q       <= '0;
			head_q        <= '0;
			nvalid_q      <= '0;
			run_q         <= '0;
			stable_q      <= 1'b0;
			stable_sym_q  <= '0;
			have_q        <= 1'b0;
			live_s1       <= 1'b0;
			ev_q          <= EV_NONE;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == ST_EMIT && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && req_type) begin
						hv_q         <= '0;
						count_q      <= '0;
						head_q       <= '0;
						nvalid_q     <= '0;
						run_q        <= '0;
						stable_q     <= 1'b0;
						stable_sym_q <= '0;
						ev_q         <= EV_NONE;
					end else if (in_acc) begin
						hv_q[wslot] <= frame_valid;
						head_q      <= new_head;
						count_q     <= keep_cnt + CNT_W'(1);
						nvalid_q    <= nvalid_q - CNT_W'(drop_valid) + CNT_W'(frame_valid);
						if (frame_valid) begin
							run_q <= '0;
						end else if (run_q != 8'hff) begin
							run_q <= run_q + 8'd1;
						end
					end
					if (cfg_acc) begin
						unique case (reg_idx_t'(cfg_index))
							REG_WINDOW_SIZE: begin
								window_size_q <= cfg_data[4:0];
								hv_q          <= '0;
								count_q       <= '0;
								head_q        <= '0;
								nvalid_q      <= '0;
							end
							REG_MIN_VOTES:    min_votes_q  <= cfg_data[4:0];
							REG_MIN_SHARE_Q8: min_share_q  <= cfg_data[8:0];
							REG_LOST_LIMIT:   lost_limit_q <= cfg_data[7:0];
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					have_q <= 1'b0;
					p_q    <= count_q - CNT_W'(1);
					if (lost) begin
						hv_q         <= '0;
						count_q      <= '0;
						head_q       <= '0;
						nvalid_q     <= '0;
						run_q        <= '0;
						stable_q     <= 1'b0;
						stable_sym_q <= '0;
						ev_q         <= EV_LOST;
					end else begin
						ev_q <= EV_NONE;
					end
				end
				ST_OUTER: begin
					if (!hv_q[p_slot] && p_q != '0) begin
						p_q <= p_q - CNT_W'(1);
					end
				end
				ST_CUR: begin
					cur_q   <= ram_rdata;
					q_q     <= '0;
					c_q     <= '0;
					seen_q  <= 1'b0;
					live_s1 <= 1'b0;
				end
				ST_INNER: begin
					if (inner_live) begin
						q_q <= q_q + CNT_W'(1);
					end
					live_s1 <= inner_live;
					pos_s1  <= q_q;
					hv_s1   <= hv_q[q_slot];
					if (live_s1 && hv_s1 && ram_rdata == cur_q) begin
						c_q <= c_q + CNT_W'(1);
						if (pos_s1 > p_q) begin
							seen_q <= 1'b1;
						end
					end
				end
				ST_EVAL: begin
					if (cand_ok) begin
						have_q     <= 1'b1;
						best_cnt_q <= c_q;
						best_sym_q <= cur_q;
					end
					if (p_q != '0) begin
						p_q <= p_q - CNT_W'(1);
					end
				end
				ST_DECIDE: begin
					if (have_q && (!stable_q || stable_sym_q != best_sym_q)) begin
						stable_q     <= 1'b1;
						stable_sym_q <= best_sym_q;
						ev_q         <= EV_CHANGED;
					end
				end
				ST_EMIT: begin
					if (emit_ok) begin
						out_ev_q     <= ev_q;
						out_has_q    <= stable_q;
						out_sym_q    <= stable_q ? stable_sym_q : '0;
						out_fill_q   <= count_q;
						out_nvalid_q <= nvalid_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign stable_ext      = 32'(out_sym_q);
	assign out_valid       = out_valid_q;
	assign vote_event      = out_ev_q;
	assign has_stable      = out_has_q;
	assign stable_id       = stable_ext[15:0];
	assign window_fill     = 5'(out_fill_q);
	assign valid_in_window = 5'(out_nvalid_q);

	a_nvalid_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		nvalid_q <= count_q)
		else $error("valid count exceeds window fill");

	a_fill_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_MAX))
		else $error("window fill exceeds window depth");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("result loaded outside emit state");

	a_no_stable_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_has_q) |-> (out_sym_q == '0))
		else $error("stable id nonzero with no stable symbol");

endmodule

`default_nettype wire

// ----- tb/sliding_window_symbol_voter_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for sliding_window_symbol_voter: directed and random frames,
// register sweeps and random back-pressure, checked against an in-bench vote predictor.
// Depends on swv_pkg and the sliding_window_symbol_voter RTL.

module sliding_window_symbol_voter_tb;
	import swv_pkg::*;

	localparam int WIN_MAX      = 16;
	localparam int IDLE_LIMIT   = 3000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 20;
	localparam bit REQ_FRAME    = 1'b0;
	localparam bit REQ_CLEAR    = 1'b1;

	typedef struct packed {
		vote_ev_t    ev;
		logic        stab;
		logic [15:0] id;
		logic [4:0]  fill;
		logic [4:0]  nvalid;
	} vote_result_t;

	class vote_scoreboard;
		logic [15:0]  hist_sym [WIN_MAX];
		bit           hist_vld [WIN_MAX];
		int           hist_cnt;
		int           hist_head;
		int           inv_run;
		bit           stab_vld;
		logic [15:0]  stab_sym;
		logic [4:0]   reg_window;
		logic [4:0]   reg_min_votes;
		logic [8:0]   reg_share;
		logic [7:0]   reg_lost;
		vote_result_t expected_votes [$];
		int           errors;

		function new();
			clear_history();
			inv_run       = 0;
			stab_vld      = 1'b0;
			stab_sym      = '0;
			reg_window    = 5'd16;
			reg_min_votes = 5'd3;
			reg_share     = 9'd128;
			reg_lost      = 8'd5;
			errors        = 0;
		endfunction

		function void clear_history();
			for (int i = 0; i < WIN_MAX; i++) begin
				hist_sym[i] = '0;
				hist_vld[i] = 1'b0;
			end
			hist_cnt  = 0;
			hist_head = 0;
		endfunction

		function int valid_frames();
			int n;
			n = 0;
			for (int p = 0; p < hist_cnt; p++)
				if (hist_vld[(hist_head + p) % WIN_MAX]) n++;
			return n;
		endfunction

		function void push_expect(vote_ev_t ev);
			vote_result_t r;
			r.ev     = ev;
			r.stab   = stab_vld;
			r.id     = stab_vld ? stab_sym : 16'h0000;
			r.fill   = 5'(hist_cnt);
			r.nvalid = 5'(valid_frames());
			expected_votes.insert(expected_votes.size(), r);
		endfunction

		function void set_reg(reg_idx_t idx, logic [8:0] data);
			case (idx)
				REG_WINDOW_SIZE: begin
					reg_window = data[4:0];
					clear_history();
				end
				REG_MIN_VOTES:    reg_min_votes = data[4:0];
				REG_MIN_SHARE_Q8: reg_share = data;
				REG_LOST_LIMIT:   reg_lost = data[7:0];
				default: ;
			endcase
		endfunction

		function void drop_stable();
			clear_history();
			stab_vld = 1'b0;
			stab_sym = '0;
			inv_run  = 0;
		endfunction

		function void tally_frame(bit req, bit fv, logic [15:0] sym);
			int          w, mv, share, limit, nval, best_cnt, c, s, p, q;
			logic [15:0] best_sym, cur;
			bit          have_best, later;
			w = (reg_window == 0) ? 1 : (reg_window > WIN_MAX) ? WIN_MAX : int'(reg_window);
			if (req == REQ_CLEAR) begin
				drop_stable();
				push_expect(EV_NONE);
				return;
			end
			// push the frame, dropping the oldest when the window is full
			if (hist_cnt >= w) begin
				hist_head = (hist_head + 1) % WIN_MAX;
				hist_cnt  = w - 1;
			end
			s = (hist_head + hist_cnt) % WIN_MAX;
			hist_sym[s] = fv ? sym : 16'h0000;
			hist_vld[s] = fv;
			hist_cnt++;
			if (fv)
				inv_run = 0;
			else if (inv_run < 255)
				inv_run++;
			limit = (reg_lost == 0) ? 1 : int'(reg_lost);
			if (stab_vld && inv_run >= limit) begin
				drop_stable();
				push_expect(EV_LOST);
				return;
			end
			mv = (reg_min_votes == 0) ? 1 : int'(reg_min_votes);
			if (mv > w) mv = w;
			share = (reg_share == 0) ? 1 : (reg_share > 256) ? 256 : int'(reg_share);
			nval = valid_frames();
			have_best = 1'b0;
			best_cnt  = 0;
			best_sym  = '0;
			// newest first; strict compare keeps the most recent symbol on a tie
			for (p = hist_cnt - 1; p >= 0; p--) begin
				s = (hist_head + p) % WIN_MAX;
				if (hist_vld[s]) begin
					cur   = hist_sym[s];
					later = 1'b0;
					for (q = p + 1; q < hist_cnt; q++)
						if (hist_vld[(hist_head + q) % WIN_MAX] &&
						    hist_sym[(hist_head + q) % WIN_MAX] == cur)
							later = 1'b1;
					if (!later) begin
						c = 0;
						for (q = 0; q <= p; q++)
							if (hist_vld[(hist_head + q) % WIN_MAX] &&
							    hist_sym[(hist_head + q) % WIN_MAX] == cur)
								c++;
						if (c >= mv && c * 256 >= share * nval && (!have_best || c > best_cnt)) begin
							have_best = 1'b1;
							best_cnt  = c;
							best_sym  = cur;
						end
					end
				end
			end
			if (have_best && (!stab_vld || stab_sym != best_sym)) begin
				stab_vld = 1'b1;
				stab_sym = best_sym;
				push_expect(EV_CHANGED);
				return;
			end
			push_expect(EV_NONE);
		endfunction

		function void check_vote(vote_result_t got);
			vote_result_t want;
			if (expected_votes.size() == 0) begin
				$display("%0t: result with no item waiting: actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_votes[0];
			expected_votes.delete(0);
			if (got.ev !== want.ev) begin
				$display("%0t: vote_event expected %0d actual %0d", $time, want.ev, got.ev);
				errors++;
			end
			if (got.stab !== want.stab) begin
				$display("%0t: has_stable expected %0d actual %0d", $time, want.stab, got.stab);
				errors++;
			end
			if (got.id !== want.id) begin
				$display("%0t: stable_id expected %h actual %h", $time, want.id, got.id);
				errors++;
			end
			if (got.fill !== want.fill) begin
				$display("%0t: window_fill expected %0d actual %0d", $time, want.fill, got.fill);
				errors++;
			end
			if (got.nvalid !== want.nvalid) begin
				$display("%0t: valid_in_window expected %0d actual %0d",
				         $time, want.nvalid, got.nvalid);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  req_type = 1'b0;
	logic                  frame_valid = 1'b0;
	logic [15:0]           symbol_id = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            vote_event;
	logic                  has_stable;
	logic [15:0]           stable_id;
	logic [4:0]            window_fill;
	logic [4:0]            valid_in_window;

	vote_scoreboard votes = new;
	vote_result_t   seen_vote;
	int             idle_cycles = 0;
	int             stall_mode = 0;
	int             stall_run = 0;
	int             mode_timer = 0;
	int             burst_left = 0;
	bit             gaps_on = 1'b1;

	sliding_window_symbol_voter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.frame_valid     (frame_valid),
		.symbol_id       (symbol_id),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.vote_event      (vote_event),
		.has_stable      (has_stable),
		.stable_id       (stable_id),
		.window_fill     (window_fill),
		.valid_in_window (valid_in_window)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// check accepted results, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_vote.ev     = vote_ev_t'(vote_event);
			seen_vote.stab   = has_stable;
			seen_vote.id     = stable_id;
			seen_vote.fill   = window_fill;
			seen_vote.nvalid = valid_in_window;
			votes.check_vote(seen_vote);
		end
		mode_timer++;
		if (mode_timer >= 250) begin
			mode_timer = 0;
			stall_mode = $urandom_range(0, 3);
		end
		if (stall_run != 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 30);
				2: out_stall <= ($urandom_range(0, 99) < 80);
				default: begin
					out_stall <= 1'b0;
					if ($urandom_range(0, 19) == 0) stall_run = $urandom_range(1, 30);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("sliding_window_symbol_voter regression: fail");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		votes.set_reg(idx, data);
	endtask

	task automatic apply_config(logic [4:0] win, logic [4:0] mv, logic [8:0] share,
	                            logic [7:0] lost);
		write_reg(REG_WINDOW_SIZE, 9'(win));
		write_reg(REG_MIN_VOTES, 9'(mv));
		write_reg(REG_MIN_SHARE_Q8, share);
		write_reg(REG_LOST_LIMIT, 9'(lost));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(bit req, bit fv, logic [15:0] sym);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		frame_valid <= fv;
		symbol_id   <= sym;
		do @(posedge clk); while (in_stall);
		votes.tally_frame(req, fv, sym);
		burst_left--;
	endtask

	task automatic send_run(bit fv, logic [15:0] sym, int n);
		repeat (n) send_item(REQ_FRAME, fv, fv ? sym : 16'($urandom));
	endtask

	// hold off until every result is back, then let the block settle
	task automatic wait_idle(int tail);
		in_valid <= 1'b0;
		burst_left = 0;
		while (votes.expected_votes.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	initial begin
		logic [15:0] pool [4];
		int          pool_n, inv_pct, drop_left, r, idx;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: change, tie to newest, lost, clear, repeat winner
		send_run(1'b1, 16'hFFFF, 3);
		send_run(1'b1, 16'h0000, 3);
		send_run(1'b0, 16'h0000, 5);
		send_item(REQ_CLEAR, 1'b1, 16'hFFFF);
		send_run(1'b1, 16'h1234, 4);
		send_item(REQ_CLEAR, 1'b0, 16'h0000);
		wait_idle(8);

		apply_config(5'd1, 5'd1, 9'd256, 8'd1);
		send_run(1'b1, 16'h8000, 1);
		send_run(1'b1, 16'h7FFF, 1);
		send_run(1'b0, 16'h0000, 1);
		wait_idle(8);

		// zero registers act as one
		apply_config(5'd0, 5'd0, 9'd0, 8'd0);
		send_run(1'b1, 16'h0001, 1);
		send_run(1'b0, 16'h0000, 1);
		wait_idle(8);

		// oversize registers clamp; long dropout reaches the top lost limit
		apply_config(5'd31, 5'd31, 9'd511, 8'd255);
		send_run(1'b1, 16'h5555, 16);
		send_run(1'b0, 16'h0000, 256);
		wait_idle(8);

		for (int ph = 0; ph < PHASES; ph++) begin
			apply_config(
				($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16)),
				($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4)),
				($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 256)),
				($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 8)));
			gaps_on = ($urandom_range(0, 3) != 0);
			pool_n = $urandom_range(1, 4);
			for (int i = 0; i < 4; i++) pool[i] = 16'($urandom);
			case ($urandom_range(0, 2))
				0: inv_pct = 5;
				1: inv_pct = 15;
				default: inv_pct = 35;
			endcase
			drop_left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (drop_left > 0) begin
					drop_left--;
					send_run(1'b0, 16'h0000, 1);
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3) begin
						send_item(REQ_CLEAR, 1'($urandom_range(0, 1)), 16'($urandom));
					end else if (r < 7) begin
						drop_left = $urandom_range(1, 12);
						send_run(1'b0, 16'h0000, 1);
					end else if (r < 7 + inv_pct) begin
						send_run(1'b0, 16'h0000, 1);
					end else if (r < 95) begin
						idx = $urandom_range(0, pool_n - 1);
						if ($urandom_range(0, 1) == 1) idx = 0;
						send_run(1'b1, pool[idx], 1);
					end else begin
						send_run(1'b1, 16'($urandom), 1);
					end
				end
			end
			wait_idle(8);
		end

		wait_idle(400);
		if (votes.errors == 0)
			$display("sliding_window_symbol_voter regression: pass");
		else
			$display("sliding_window_symbol_voter regression: fail");
		$finish;
	end

endmodule
